### design/tcw_pkg.sv
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int CNT_W  = $clog2(CELL_COUNT + 1);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int CELL_W = 16;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] GREY_ATTR    = 8'h07;
	localparam logic [CELL_W-1:0] BLANK_CELL = {GREY_ATTR, SPACE_CODE};

	typedef enum logic [1:0] {
		FN_PUT   = 2'd0,
		FN_ATTR  = 2'd1,
		FN_CLEAR = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [4:0]        row;
		logic [6:0]        col;
		logic [10:0]       linear;
		logic [CELL_W-1:0] word;
	} rsp_t;

endpackage

### design/tcw_ram.sv
module tcw_ram
	import tcw_pkg::*;
(
	input  logic              clk,
	input  ram_req_t          req,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [CELL_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

### design/tcw_seq.sv
module tcw_seq
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [1:0]        func,
	input  logic [7:0]        char_code,
	input  logic [7:0]        attr_value,
	input  logic [10:0]       cell_index,
	output logic              done,
	input  logic              take,
	output rsp_t              rsp,
	output ram_req_t          ram_req,
	input  logic [CELL_W-1:0] ram_rdata
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_EXEC   = 7'b0000010,
		ST_RDWAIT = 7'b0000100,
		ST_COPY   = 7'b0001000,
		ST_BLANK  = 7'b0010000,
		ST_FILL   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               init_q;
	logic [ROW_W-1:0]   cursor_row_q;
	logic [COL_W-1:0]   cursor_col_q;
	logic [7:0]         attr_q;
	logic               wr_pend_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;

	func_t              func_q;
	logic [7:0]         char_q;
	logic [7:0]         attr_in_q;
	logic [10:0]        index_q;
	logic [CELL_W-1:0]  word_q;

	logic               accept;
	logic [ADDR_W-1:0]  cursor_lin;
	logic               index_ok;
	logic               is_newline;
	logic               col_at_end;
	logic               row_at_end;
	logic               copy_more;

	assign req_stall  = !(state_q == ST_IDLE || (state_q == ST_DONE && take));
	assign accept     = req_valid && !req_stall;
	assign done       = (state_q == ST_DONE);
	assign cursor_lin = ADDR_W'(cursor_row_q * COLUMNS + cursor_col_q);
	assign index_ok   = (32'(index_q) < CELL_COUNT);
	assign is_newline = (char_q == NEWLINE_CODE);
	assign col_at_end = (cursor_col_q == COL_W'(COLUMNS - 1));
	assign row_at_end = (cursor_row_q == ROW_W'(ROWS - 1));
	assign copy_more  = (cnt_q < CNT_W'(CELL_COUNT));

	assign rsp.row    = 5'(cursor_row_q);
	assign rsp.col    = 7'(cursor_col_q);
	assign rsp.linear = 11'(cursor_lin);
	assign rsp.word   = word_q;

	always_comb begin
		ram_req = '0;
		unique case (state_q)
			ST_EXEC: begin
				if (func_q == FN_PUT && !is_newline) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = cursor_lin;
					ram_req.wdata = {attr_q, char_q};
				end
				if (func_q == FN_READ && index_ok) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = ADDR_W'(index_q);
				end
			end
			ST_COPY: begin
				// Reads run one row ahead of writes, so a copy never reads a cell
				// that is still waiting to be written.
				ram_req.re    = copy_more;
				ram_req.raddr = cnt_q[ADDR_W-1:0];
				ram_req.we    = wr_pend_s1;
				ram_req.waddr = wr_addr_s1;
				ram_req.wdata = ram_rdata;
			end
			ST_BLANK: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q[ADDR_W-1:0];
				ram_req.wdata = {attr_q, SPACE_CODE};
			end
			ST_FILL: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q[ADDR_W-1:0];
				ram_req.wdata = BLANK_CELL;
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			cnt_q        <= '0;
			init_q       <= 1'b1;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			attr_q       <= GREY_ATTR;
			wr_pend_s1   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE, ST_DONE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end else if (state_q == ST_DONE && take) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EXEC: begin
					unique case (func_q)
						FN_PUT: begin
							if (is_newline || col_at_end) begin
								cursor_col_q <= '0;
								if (row_at_end) begin
									cnt_q      <= CNT_W'(COLUMNS);
									wr_pend_s1 <= 1'b0;
									state_q    <= ST_COPY;
								end else begin
									cursor_row_q <= cursor_row_q + 1'b1;
									state_q      <= ST_DONE;
								end
							end else begin
								cursor_col_q <= cursor_col_q + 1'b1;
								state_q      <= ST_DONE;
							end
						end
						FN_ATTR: begin
							attr_q  <= attr_in_q;
							state_q <= ST_DONE;
						end
						FN_CLEAR: begin
							attr_q       <= GREY_ATTR;
							cursor_row_q <= '0;
							cursor_col_q <= '0;
							cnt_q        <= '0;
							state_q      <= ST_FILL;
						end
						FN_READ: begin
							state_q <= index_ok ? ST_RDWAIT : ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_RDWAIT: begin
					state_q <= ST_DONE;
				end
				ST_COPY: begin
					if (copy_more) begin
						cnt_q      <= cnt_q + 1'b1;
						wr_pend_s1 <= 1'b1;
					end else begin
						// The last copy write drains in this cycle.
						wr_pend_s1 <= 1'b0;
						cnt_q      <= CNT_W'((ROWS - 1) * COLUMNS);
						state_q    <= ST_BLANK;
					end
				end
				ST_BLANK: begin
					if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FILL: begin
					if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
						state_q <= init_q ? ST_IDLE : ST_DONE;
						init_q  <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func_t'(func);
			char_q    <= char_code;
			attr_in_q <= attr_value;
			index_q   <= cell_index;
		end
		if (state_q == ST_EXEC) begin
			word_q <= '0;
		end
		if (state_q == ST_RDWAIT) begin
			word_q <= ram_rdata;
		end
		if (state_q == ST_COPY) begin
			wr_addr_s1 <= ADDR_W'(cnt_q - CNT_W'(COLUMNS));
		end
	end

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cursor_row_q) < ROWS) && (32'(cursor_col_q) < COLUMNS))
		else $error("cursor left the screen");

	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> (CNT_W'(wr_addr_s1) + CNT_W'(COLUMNS + 1) == cnt_q))
		else $error("scroll copy write does not trail its read by one row");

	a_copy_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLANK) |-> !wr_pend_s1)
		else $error("copy write still pending while blanking the last row");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (req_stall && !done))
		else $error("transaction accepted while another is in flight");

endmodule

### design/text_console_writer.sv
// Flow: an accepted request passes through the execute state, then the done state, and its
// result is then registered into the output that drives rsp_valid; an in-range read adds a
// read-wait state, a put that scrolls adds the row copy and blank states, and a clear the fill.
// The sequencer works on one transaction at a time: a new request is taken only once the last
// one has reached its done state and its result is passed to the output register.
// Reset: cursor to home, attribute light grey; after reset the screen RAM is filled with
// grey spaces, and req_stall stays high until the fill is done.
module text_console_writer
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attr_value,
	input  logic [10:0] cell_index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [4:0]  cursor_row_out,
	output logic [6:0]  cursor_col_out,
	output logic [10:0] cursor_linear,
	output logic [15:0] cell_word
);

	ram_req_t          ram_req;
	logic [CELL_W-1:0] ram_rdata;
	logic              seq_done;
	logic              seq_take;
	rsp_t              seq_rsp;
	logic              out_valid_q;
	rsp_t              out_q;

	tcw_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	tcw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.char_code  (char_code),
		.attr_value (attr_value),
		.cell_index (cell_index),
		.done       (seq_done),
		.take       (seq_take),
		.rsp        (seq_rsp),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata)
	);

	assign seq_take = seq_done && (!out_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_take) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_take) begin
			out_q <= seq_rsp;
		end
	end

	assign rsp_valid      = out_valid_q;
	assign cursor_row_out = out_q.row;
	assign cursor_col_out = out_q.col;
	assign cursor_linear  = out_q.linear;
	assign cell_word      = out_q.word;

endmodule

### test/text_console_writer_tb.sv
module text_console_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int     RANDOM_ITEMS = 2000;
	localparam int     QUIET_TAIL   = 200;
	localparam int     LONG_HOLD_AT = 400;
	localparam int     DRAIN_AT     = 1000;
	localparam int     HOLD_CYCLES  = 400;
	localparam longint CYCLE_LIMIT  = 20_000_000;

	typedef struct {
		func_t       fn;
		logic [7:0]  ch;
		logic [7:0]  attr;
		logic [10:0] idx;
		int          reps;
		bit          fixed;
		rsp_t        want;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  func;
	logic [7:0]  char_code;
	logic [7:0]  attr_value;
	logic [10:0] cell_index;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [4:0]  cursor_row_out;
	logic [6:0]  cursor_col_out;
	logic [10:0] cursor_linear;
	logic [15:0] cell_word;

	// Shadow copy of the screen and cursor, advanced once per accepted transaction.
	logic [15:0] shadow_cells [CELL_COUNT];
	int unsigned cur_row;
	int unsigned cur_col;
	logic [7:0]  cur_attr;

	rsp_t   cursor_reports_due [$];
	rsp_t   report_due;
	int     fail_count = 0;
	longint cycle_count = 0;
	bit     quiet = 1'b0;
	bit     gappy = 1'b1;
	bit     hold_long = 1'b0;

	step_t plan [25] = '{
		'{FN_READ,  8'h00, 8'h00, 11'd0,    1,  1'b1, '{5'd0, 7'd0, 11'd0,  16'h0720}},
		'{FN_READ,  8'h00, 8'h00, 11'd1999, 1,  1'b1, '{5'd0, 7'd0, 11'd0,  16'h0720}},
		'{FN_READ,  8'h00, 8'h00, 11'd2000, 1,  1'b1, '{5'd0, 7'd0, 11'd0,  16'h0000}},
		'{FN_READ,  8'hFF, 8'hFF, 11'h7FF,  1,  1'b1, '{5'd0, 7'd0, 11'd0,  16'h0000}},
		'{FN_PUT,   8'h41, 8'hFF, 11'h7FF,  1,  1'b1, '{5'd0, 7'd1, 11'd1,  16'h0000}},
		'{FN_READ,  8'h00, 8'h00, 11'd0,    1,  1'b1, '{5'd0, 7'd1, 11'd1,  16'h0741}},
		'{FN_ATTR,  8'h0A, 8'hFF, 11'd0,    1,  1'b1, '{5'd0, 7'd1, 11'd1,  16'h0000}},
		'{FN_PUT,   8'h00, 8'h00, 11'd0,    1,  1'b1, '{5'd0, 7'd2, 11'd2,  16'h0000}},
		'{FN_PUT,   8'hFF, 8'h00, 11'd0,    1,  1'b1, '{5'd0, 7'd3, 11'd3,  16'h0000}},
		'{FN_PUT,   8'h08, 8'h00, 11'd0,    1,  1'b1, '{5'd0, 7'd4, 11'd4,  16'h0000}},
		'{FN_READ,  8'h00, 8'h00, 11'd3,    1,  1'b1, '{5'd0, 7'd4, 11'd4,  16'hFF08}},
		'{FN_PUT,   8'h0A, 8'h00, 11'd0,    1,  1'b1, '{5'd1, 7'd0, 11'd80, 16'h0000}},
		'{FN_CLEAR, 8'hFF, 8'hFF, 11'h7FF,  1,  1'b1, '{5'd0, 7'd0, 11'd0,  16'h0000}},
		'{FN_READ,  8'h00, 8'h00, 11'd1,    1,  1'b1, '{5'd0, 7'd0, 11'd0,  16'h0720}},
		'{FN_ATTR,  8'h00, 8'h1E, 11'd0,    1,  1'b0, '0},
		'{FN_PUT,   8'h78, 8'h00, 11'd0,    82, 1'b0, '0},
		'{FN_PUT,   8'h0A, 8'h00, 11'd0,    25, 1'b0, '0},
		'{FN_READ,  8'h00, 8'h00, 11'd1920, 1,  1'b0, '0},
		'{FN_READ,  8'h00, 8'h00, 11'd0,    1,  1'b0, '0},
		'{FN_ATTR,  8'h00, 8'h00, 11'd0,    1,  1'b0, '0},
		'{FN_PUT,   8'h7E, 8'h00, 11'd0,    81, 1'b0, '0},
		'{FN_READ,  8'h00, 8'h00, 11'd1999, 1,  1'b0, '0},
		'{FN_READ,  8'h00, 8'h00, 11'd1919, 1,  1'b0, '0},
		'{FN_CLEAR, 8'h00, 8'h00, 11'd0,    1,  1'b0, '0},
		'{FN_READ,  8'h00, 8'h00, 11'd1999, 1,  1'b1, '{5'd0, 7'd0, 11'd0,  16'h0720}}
	};

	text_console_writer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.func          (func),
		.char_code     (char_code),
		.attr_value    (attr_value),
		.cell_index    (cell_index),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.cursor_row_out(cursor_row_out),
		.cursor_col_out(cursor_col_out),
		.cursor_linear (cursor_linear),
		.cell_word     (cell_word)
	);

	always #10 clk = ~clk;

	function automatic void blank_screen();
		for (int i = 0; i < CELL_COUNT; i++)
			shadow_cells[i] = BLANK_CELL;
		cur_row  = 0;
		cur_col  = 0;
		cur_attr = GREY_ATTR;
	endfunction

	// Past the last row everything moves up one row and the freed row is blanked
	// in the current attribute.
	function automatic void advance_row();
		int unsigned last;
		last = (ROWS - 1) * COLUMNS;
		cur_row++;
		if (cur_row >= ROWS) begin
			cur_row = ROWS - 1;
			for (int i = 0; i < last; i++)
				shadow_cells[i] = shadow_cells[i + COLUMNS];
			for (int i = 0; i < COLUMNS; i++)
				shadow_cells[last + i] = {cur_attr, SPACE_CODE};
		end
	endfunction

	function automatic rsp_t apply_console_item(input func_t fn, input logic [7:0] ch,
			input logic [7:0] attr, input logic [10:0] idx);
		rsp_t        r;
		int unsigned lin;
		r = '0;
		case (fn)
			FN_PUT: begin
				if (ch == NEWLINE_CODE) begin
					cur_col = 0;
					advance_row();
				end else begin
					shadow_cells[cur_row * COLUMNS + cur_col] = {cur_attr, ch};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						advance_row();
					end
				end
			end
			FN_ATTR: begin
				cur_attr = attr;
			end
			FN_CLEAR: begin
				blank_screen();
			end
			default: begin
				if (idx < CELL_COUNT)
					r.word = shadow_cells[idx];
			end
		endcase
		lin      = cur_row * COLUMNS + cur_col;
		r.row    = cur_row[4:0];
		r.col    = cur_col[6:0];
		r.linear = lin[10:0];
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the handshake.
	task automatic offer_item(input func_t fn, input logic [7:0] ch, input logic [7:0] attr,
			input logic [10:0] idx, input bit fixed, input rsp_t want);
		rsp_t predicted;
		req_valid  = 1'b1;
		func       = fn;
		char_code  = ch;
		attr_value = attr;
		cell_index = idx;
		do
			@(posedge clk);
		while (req_stall);
		predicted = apply_console_item(fn, ch, attr, idx);
		cursor_reports_due.push_back(fixed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	initial begin
		func_t       fn;
		logic [7:0]  ch;
		logic [10:0] idx;
		int unsigned lin;
		int unsigned pick;

		arst_n     = 1'b0;
		req_valid  = 1'b0;
		func       = FN_PUT;
		char_code  = '0;
		attr_value = '0;
		cell_index = '0;
		blank_screen();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[s]) begin
			for (int k = 0; k < plan[s].reps; k++) begin
				sender_gap();
				offer_item(plan[s].fn, plan[s].ch, plan[s].attr, plan[s].idx,
					plan[s].fixed, plan[s].want);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				gappy = $urandom_range(0, 3) != 0;
			if (n == LONG_HOLD_AT)
				hold_long = 1'b1;
			if (n == DRAIN_AT) begin
				req_valid = 1'b0;
				while (cursor_reports_due.size() != 0)
					@(negedge clk);
			end
			if (n == RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1'b1;

			ch   = 8'($urandom_range(0, 255));
			idx  = 11'($urandom_range(0, 2047));
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				fn = FN_CLEAR;
			end else if (pick < 10) begin
				fn = FN_ATTR;
			end else if (pick < 30) begin
				fn  = FN_READ;
				lin = cur_row * COLUMNS + cur_col;
				case ($urandom_range(0, 3))
					0: idx = 11'($urandom_range(0, CELL_COUNT - 1));
					1: idx = 11'((ROWS - 1) * COLUMNS + $urandom_range(0, COLUMNS - 1));
					2: idx = 11'(lin - $urandom_range(0, (lin > 3) ? 3 : lin));
					default: ;
				endcase
			end else begin
				fn = FN_PUT;
				if ($urandom_range(0, 9) == 0)
					ch = NEWLINE_CODE;
			end
			sender_gap();
			offer_item(fn, ch, 8'($urandom_range(0, 255)), idx, 1'b0, '0);
		end

		req_valid = 1'b0;
		while (cursor_reports_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("text_console_writer_tb OK");
		else
			$display("text_console_writer_tb NOT OK");
		$finish;
	end

	// Receiver side: random stall bursts, one long hold-off, and none in the tail.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_long) begin
				rsp_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_stall = 1'b0;
				hold_long = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_stall = 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				rsp_stall = 1'b0;
			end else if (!quiet) begin
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (cursor_reports_due.size() == 0) begin
				$error("unexpected transaction: row %0d col %0d word %h",
					cursor_row_out, cursor_col_out, cell_word);
				fail_count++;
			end else begin
				report_due = cursor_reports_due.pop_front();
				if (cursor_row_out !== report_due.row) begin
					$error("cursor_row_out: expected %0d, got %0d", report_due.row,
						cursor_row_out);
					fail_count++;
				end
				if (cursor_col_out !== report_due.col) begin
					$error("cursor_col_out: expected %0d, got %0d", report_due.col,
						cursor_col_out);
					fail_count++;
				end
				if (cursor_linear !== report_due.linear) begin
					$error("cursor_linear: expected %0d, got %0d", report_due.linear,
						cursor_linear);
					fail_count++;
				end
				if (cell_word !== report_due.word) begin
					$error("cell_word: expected %h, got %h", report_due.word, cell_word);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("text_console_writer_tb NOT OK");
			$finish;
		end
	end

endmodule
